[hdl/ufc_pkg.sv]
// Shared types and constants for the buffered serial-port queue controller.
package ufc_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH    = 2'd0,
    MODE_POP     = 2'd1,
    MODE_SERVICE = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  localparam logic [7:0] NO_BYTE = 8'hFF;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

endpackage

[hdl/ufc_in_if.sv]
// Request channel carrying host push, host pop and service events.
interface ufc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic       rx_full_flag;
  logic       tx_empty_flag;

  modport source (output valid, mode, data_byte, rx_full_flag, tx_empty_flag, input ready);
  modport sink (input valid, mode, data_byte, rx_full_flag, tx_empty_flag, output ready);
endinterface

[hdl/ufc_out_if.sv]
// Result channel carrying one status word per request.
interface ufc_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [7:0] read_byte;
  logic       tx_write_valid;
  logic [7:0] tx_write_byte;
  logic       rx_dropped;
  logic       tx_irq_on;
  logic       tx_queue_empty;
  logic       rx_queue_empty;

  modport source (output valid, accepted, read_byte, tx_write_valid, tx_write_byte,
                  rx_dropped, tx_irq_on, tx_queue_empty, rx_queue_empty, input ready);
  modport sink (input valid, accepted, read_byte, tx_write_valid, tx_write_byte,
                rx_dropped, tx_irq_on, tx_queue_empty, rx_queue_empty, output ready);
endinterface

[hdl/ufc_cfg_if.sv]
// Configuration write channel for the enable register.
interface ufc_cfg_if;
  logic valid;
  logic ready;
  logic enabled;

  modport source (output valid, enabled, input ready);
  modport sink (input valid, enabled, output ready);
endinterface

[hdl/ufc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ufc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/uart_buffered_fifo_controller.sv]
// Buffered serial-port queue controller: transmit and receive ring buffers.
// A request's result is offered in the cycle after the request is taken.
// One request per cycle while the result output is not stalled; the queue RAMs' read data is registered.
// A new request is taken whenever the result register is empty or being drained.
// Reset (synchronous, rst_n low) clears pointers, interrupt enable and the enable register;
// queue RAM contents are not cleared.
module uart_buffered_fifo_controller
  import ufc_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ufc_in_if.sink    in_ch,
  ufc_out_if.source out_ch,
  ufc_cfg_if.sink   cfg_ch
);

  localparam int PW = $clog2(DEPTH);

  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
    next_pos = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic          enabled_r, enabled_nxt;
  logic          irq_r, irq_nxt;
  logic [PW-1:0] tx_wr_r, tx_wr_nxt, tx_rd_r, tx_rd_nxt;
  logic [PW-1:0] rx_wr_r, rx_wr_nxt, rx_rd_r, rx_rd_nxt;
  logic          v_r, v_nxt;
  logic          acc_r, pop_r, send_r, drop_r;

  mode_t md;
  logic  in_fire;
  logic  tx_empty, tx_full, rx_empty, rx_full;
  logic  do_push, do_pop, do_store, do_drop, tx_try, do_send, irq_clear;
  logic [7:0] tx_rdata, rx_rdata;

  assign md      = mode_t'(in_ch.mode);
  assign in_ch.ready = !v_r || out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign tx_empty = (tx_wr_r == tx_rd_r);
  assign tx_full  = (next_pos(tx_wr_r) == tx_rd_r);
  assign rx_empty = (rx_wr_r == rx_rd_r);
  assign rx_full  = (next_pos(rx_wr_r) == rx_rd_r);

  always_comb begin
    do_push   = (md == MODE_PUSH) && enabled_r && !tx_full;
    do_pop    = (md == MODE_POP) && enabled_r && !rx_empty;
    do_store  = (md == MODE_SERVICE) && in_ch.rx_full_flag && !rx_full;
    do_drop   = (md == MODE_SERVICE) && in_ch.rx_full_flag && rx_full;
    tx_try    = (md == MODE_SERVICE) && in_ch.tx_empty_flag && irq_r;
    do_send   = tx_try && !tx_empty;
    irq_clear = tx_try && tx_empty;

    enabled_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.enabled : enabled_r;
    tx_wr_nxt = tx_wr_r;
    tx_rd_nxt = tx_rd_r;
    rx_wr_nxt = rx_wr_r;
    rx_rd_nxt = rx_rd_r;
    irq_nxt   = irq_r;
    v_nxt     = v_r && !out_ch.ready;
    if (in_fire) begin
      v_nxt = 1'b1;
      if (do_push) begin
        tx_wr_nxt = next_pos(tx_wr_r);
        irq_nxt   = 1'b1;
      end
      if (do_pop) begin
        rx_rd_nxt = next_pos(rx_rd_r);
      end
      if (do_store) begin
        rx_wr_nxt = next_pos(rx_wr_r);
      end
      if (do_send) begin
        tx_rd_nxt = next_pos(tx_rd_r);
      end
      if (irq_clear) begin
        irq_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      irq_r     <= 1'b0;
      tx_wr_r   <= '0;
      tx_rd_r   <= '0;
      rx_wr_r   <= '0;
      rx_rd_r   <= '0;
      v_r       <= 1'b0;
    end else begin
      enabled_r <= enabled_nxt;
      irq_r     <= irq_nxt;
      tx_wr_r   <= tx_wr_nxt;
      tx_rd_r   <= tx_rd_nxt;
      rx_wr_r   <= rx_wr_nxt;
      rx_rd_r   <= rx_rd_nxt;
      v_r       <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_r  <= do_push || do_pop;
      pop_r  <= do_pop;
      send_r <= do_send;
      drop_r <= do_drop;
    end
  end

  ufc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (in_fire && do_push),
    .waddr (tx_wr_r),
    .wdata (in_ch.data_byte),
    .re    (in_fire && do_send),
    .raddr (tx_rd_r),
    .rdata (tx_rdata)
  );

  ufc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (in_fire && do_store),
    .waddr (rx_wr_r),
    .wdata (in_ch.data_byte),
    .re    (in_fire && do_pop),
    .raddr (rx_rd_r),
    .rdata (rx_rdata)
  );

  assign out_ch.valid          = v_r;
  assign out_ch.accepted       = acc_r;
  assign out_ch.read_byte      = pop_r ? rx_rdata : NO_BYTE;
  assign out_ch.tx_write_valid = send_r;
  assign out_ch.tx_write_byte  = send_r ? tx_rdata : ZERO_BYTE;
  assign out_ch.rx_dropped     = drop_r;
  assign out_ch.tx_irq_on      = irq_r;
  assign out_ch.tx_queue_empty = enabled_r && tx_empty;
  assign out_ch.rx_queue_empty = rx_empty;

`ifndef ASSERT_OFF
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && do_push |=> !tx_empty && irq_r)
    else $error("accepted push left transmit queue empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !out_ch.ready |=> $stable(tx_rd_r) && $stable(rx_rd_r) && $stable(irq_r))
    else $error("queue state moved while result stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v_r)
    else $error("request taken without a result");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    tx_wr_r <= PW'(DEPTH - 1) && tx_rd_r <= PW'(DEPTH - 1) &&
    rx_wr_r <= PW'(DEPTH - 1) && rx_rd_r <= PW'(DEPTH - 1))
    else $error("queue pointer beyond depth");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> $onehot0({acc_r, send_r}) && !(pop_r && drop_r))
    else $error("conflicting result flags");
`endif

endmodule
